// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON string unescaper
// Mode and status codes, and the command word passed from the front end to
// the result serializer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_DONE     = 3'd1,
    ST_NOT_STR  = 3'd2,
    ST_EOF_STR  = 3'd3,
    ST_BAD_HEX  = 3'd4,
    ST_EOF_ESC  = 3'd5
  } status_e;

  // One command yields 1 to 3 results; bytes[0] goes out first.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt_m1;
    status_e         status;
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

endpackage

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: byte classifier and escape decoder
// Runs the string/escape/hex state machine on each accepted byte and emits at
// most one command per byte into the queue.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,       // byte transfer this cycle
  input  logic [7:0] byte_i,
  input  logic       eof_i,
  output logic       cmd_valid_o,  // qualified by take_i
  output cmd_t       cmd_o
);

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] cp_q, cp_d;

  logic [4:0]  hex_dig;   // bit 4 flags a non-hex byte
  logic [15:0] cp_new;

  always_comb begin
    hex_dig = 5'h10;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) hex_dig = {1'b0, 4'(byte_i - 8'h30)};
    else if (byte_i >= 8'h41 && byte_i <= 8'h46) hex_dig = {1'b0, 4'(byte_i - 8'h37)};
    else if (byte_i >= 8'h61 && byte_i <= 8'h66) hex_dig = {1'b0, 4'(byte_i - 8'h57)};
  end

  assign cp_new = {cp_q[11:0], hex_dig[3:0]};

  always_comb begin
    mode_d      = mode_q;
    hex_cnt_d   = hex_cnt_q;
    cp_d        = cp_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.status = ST_BYTE;
    unique case (mode_q)
      MODE_IDLE: begin
        if (!eof_i && !(byte_i == 8'h20 || (byte_i >= 8'h09 && byte_i <= 8'h0D))) begin
          if (byte_i == 8'h22) begin
            mode_d = MODE_STR;
          end else begin
            cmd_valid_o  = 1'b1;
            cmd_o.status = ST_NOT_STR;
          end
        end
      end
      MODE_STR: begin
        if (eof_i) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_EOF_STR;
          mode_d       = MODE_IDLE;
        end else if (byte_i == 8'h22) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_DONE;
          mode_d       = MODE_IDLE;
        end else if (byte_i == 8'h5C) begin
          mode_d = MODE_ESC;
        end else begin
          cmd_valid_o    = 1'b1;
          cmd_o.bytes[0] = byte_i;
        end
      end
      MODE_ESC: begin
        if (eof_i) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_EOF_ESC;
          mode_d       = MODE_IDLE;
        end else begin
          mode_d         = MODE_STR;
          cmd_valid_o    = 1'b1;
          cmd_o.bytes[0] = byte_i;
          unique case (byte_i)
            8'h62:   cmd_o.bytes[0] = 8'h08;  // b
            8'h66:   cmd_o.bytes[0] = 8'h0C;  // f
            8'h6E:   cmd_o.bytes[0] = 8'h0A;  // n
            8'h72:   cmd_o.bytes[0] = 8'h0D;  // r
            8'h74:   cmd_o.bytes[0] = 8'h09;  // t
            8'h75: begin                      // u: start hex digits
              cmd_valid_o = 1'b0;
              mode_d      = MODE_HEX;
              hex_cnt_d   = '0;
              cp_d        = '0;
            end
            default: cmd_o.bytes[0] = byte_i;
          endcase
        end
      end
      MODE_HEX: begin
        if (eof_i || hex_dig[4]) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_BAD_HEX;
          mode_d       = MODE_IDLE;
          hex_cnt_d    = '0;
          cp_d         = '0;
        end else begin
          cp_d = cp_new;
          if (hex_cnt_q == 2'd3) begin
            mode_d      = MODE_STR;
            hex_cnt_d   = '0;
            cmd_valid_o = 1'b1;
            if (cp_new <= 16'h007F) begin
              cmd_o.bytes[0] = cp_new[7:0];
            end else if (cp_new <= 16'h07FF) begin
              cmd_o.cnt_m1   = 2'd1;
              cmd_o.bytes[0] = 8'hC0 | {3'b000, cp_new[10:6]};
              cmd_o.bytes[1] = 8'h80 | {2'b00, cp_new[5:0]};
            end else begin
              cmd_o.cnt_m1   = 2'd2;
              cmd_o.bytes[0] = 8'hE0 | {4'h0, cp_new[15:12]};
              cmd_o.bytes[1] = 8'h80 | {2'b00, cp_new[11:6]};
              cmd_o.bytes[2] = 8'h80 | {2'b00, cp_new[5:0]};
            end
          end else begin
            hex_cnt_d = hex_cnt_q + 2'd1;
          end
        end
      end
      default: mode_d = MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      hex_cnt_q <= '0;
      cp_q      <= '0;
    end else if (take_i) begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

endmodule

// File: rtl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo: command queue
// Small register queue decoupling the decoder from the result serializer.
// ----------------------------------------------------------------------------
module jsu_fifo
  import jsu_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: result serializer
// Steps through the 1 to 3 results of the queue head, one per transfer.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  logic [1:0] idx_q, idx_d;
  logic       xfer;

  assign valid_o  = !empty_i;
  assign xfer     = valid_o && ready_i;
  assign last_o   = (idx_q == cmd_i.cnt_m1);
  assign pop_o    = xfer && last_o;
  assign status_o = cmd_i.status;

  always_comb begin
    unique case (idx_q)
      2'd0:    byte_o = cmd_i.bytes[0];
      2'd1:    byte_o = cmd_i.bytes[1];
      default: byte_o = cmd_i.bytes[2];
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (xfer) idx_d = last_o ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// File: rtl/json_string_unescaper_top.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_top: JSON string literal decoder to UTF-8 bytes
// A result waits in the command queue before it is offered on the output.
// Throughput: one input byte per cycle; one result per cycle on the output while
// m_axis_tready is high; a \u escape yields up to 3 results, drained from the command queue.
// Input stalls only when the FifoDepth-entry command queue is full.
// Reset: asynchronous, active low; decoder returns to idle, queue empties.
// ----------------------------------------------------------------------------
module json_string_unescaper_top
  import jsu_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_input
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [2:0] status
  output logic       m_axis_tlast    // last result of this input byte
);

  logic take;
  logic cmd_valid;
  cmd_t cmd_in, cmd_head;
  logic full, empty, pop;

  // Front end runs whenever the queue has room; bytes that give no result (whitespace
  // outside a string, opening quote, backslash, u, first three hex digits) only move the decoder state.
  assign s_axis_tready = !full;
  assign take          = s_axis_tvalid && s_axis_tready;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (s_axis_tdata),
    .eof_i       (s_axis_tlast),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in)
  );

  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && cmd_valid),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .empty_o (empty)
  );

  // Back end expands the head command into its results, popping on the last.
  jsu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .cmd_i    (cmd_head),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .byte_o   (m_axis_tdata),
    .status_o (m_axis_tuser),
    .last_o   (m_axis_tlast)
  );

endmodule
